/* hdl/tvt_pkg.sv */
package tvt_pkg;

   localparam int TABLE_POINTS = 33;
   localparam int SEG_W = $clog2(TABLE_POINTS);
   localparam int VOLT_W = 16;
   localparam int TEMP_W = 15;
   localparam int PROD_W = 32;
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W = $clog2(DIV_STEPS);

   // Table voltages in 0.1 mV units, strictly falling.
   localparam logic [VOLT_W-1:0] VOLT_TAB [TABLE_POINTS] = '{
      16'd24400, 16'd24200, 16'd24000, 16'd23800, 16'd23500, 16'd23200, 16'd22700,
      16'd22300, 16'd21700, 16'd21100, 16'd20500, 16'd19900, 16'd19200, 16'd18600,
      16'd18000, 16'd17400, 16'd16800, 16'd16300, 16'd15900, 16'd15500, 16'd15100,
      16'd14800, 16'd14500, 16'd14300, 16'd14000, 16'd13800, 16'd13700, 16'd13500,
      16'd13400, 16'd13300, 16'd13200, 16'd13100, 16'd13000
   };

   // Table temperatures in 0.01 degC units.
   localparam logic signed [TEMP_W-1:0] TEMP_TAB [TABLE_POINTS] = '{
      -15'sd4000, -15'sd3500, -15'sd3000, -15'sd2500, -15'sd2000, -15'sd1500,
      -15'sd1000, -15'sd500, 15'sd0, 15'sd500, 15'sd1000, 15'sd1500, 15'sd2000,
      15'sd2500, 15'sd3000, 15'sd3500, 15'sd4000, 15'sd4500, 15'sd5000, 15'sd5500,
      15'sd6000, 15'sd6500, 15'sd7000, 15'sd7500, 15'sd8000, 15'sd8500, 15'sd9000,
      15'sd9500, 15'sd10000, 15'sd10500, 15'sd11000, 15'sd11500, 15'sd12000
   };

   typedef struct packed {
      logic load;
      logic seg_inc;
      logic mul_load;
      logic div_init;
      logic div_step;
      logic res_load;
   } tvt_cmd_type;

   typedef struct packed {
      logic oor;
      logic seg_hit;
   } tvt_sts_type;

endpackage

/* hdl/tvt_dp.sv */
module tvt_dp
   import tvt_pkg::*;
(
   input  logic                     clock,
   input  logic [VOLT_W-1:0]        req_sense_voltage,
   input  tvt_cmd_type              cmd,
   output tvt_sts_type              sts,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_out_of_range
);

   logic [VOLT_W-1:0]        v_ff;
   logic [SEG_W-1:0]         seg_ff;
   logic [SEG_W-1:0]         seg_nxt;
   logic [VOLT_W-1:0]        x1;
   logic [VOLT_W-1:0]        x2;
   logic signed [TEMP_W-1:0] y1;
   logic signed [TEMP_W-1:0] y2;
   logic [VOLT_W-1:0]        diff;
   logic signed [TEMP_W:0]   dy;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [VOLT_W-1:0]        den_ff;
   logic signed [TEMP_W-1:0] y1_ff;
   logic [PROD_W-1:0]        mag;
   logic                     neg_ff;
   logic                     zden_ff;
   logic [VOLT_W:0]          rem_ff;
   logic [PROD_W-1:0]        quo_ff;
   logic [VOLT_W:0]          rem_sh;
   logic [PROD_W-1:0]        quo_s;
   logic [PROD_W-1:0]        sum;
   logic signed [TEMP_W-1:0] temp_ff;
   logic                     oor_ff;

   assign seg_nxt = seg_ff + 1'b1;
   assign x1 = VOLT_TAB[seg_ff];
   assign x2 = VOLT_TAB[seg_nxt];
   assign y1 = TEMP_TAB[seg_ff];
   assign y2 = TEMP_TAB[seg_nxt];

   assign sts.oor = (v_ff > VOLT_TAB[0]) || (v_ff < VOLT_TAB[TABLE_POINTS-1]);
   assign sts.seg_hit = (seg_ff == SEG_W'(TABLE_POINTS - 2)) || (v_ff > x2);

   // The input never exceeds x1 inside the table, so x1 - v is a magnitude.
   assign diff = x1 - v_ff;
   assign dy = {y2[TEMP_W-1], y2} - {y1[TEMP_W-1], y1};
   assign prod_in = PROD_W'($signed({1'b0, diff}) * dy);

   assign mag = prod_ff[PROD_W-1] ? (~prod_ff + 1'b1) : prod_ff;
   assign rem_sh = {rem_ff[VOLT_W-1:0], quo_ff[PROD_W-1]};
   assign quo_s = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign sum = {{(PROD_W-TEMP_W){y1_ff[TEMP_W-1]}}, y1_ff} + quo_s;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff <= req_sense_voltage;
         seg_ff <= '0;
      end else if (cmd.seg_inc) begin
         seg_ff <= seg_nxt;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
         den_ff <= x1 - x2;
         y1_ff <= y1;
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= mag;
         neg_ff <= prod_ff[PROD_W-1];
         zden_ff <= (den_ff == '0);
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[PROD_W-2:0], 1'b0};
         end
      end
      if (cmd.res_load) begin
         oor_ff <= sts.oor;
         if (sts.oor) begin
            temp_ff <= '0;
         end else if (zden_ff) begin
            temp_ff <= y1_ff;
         end else begin
            temp_ff <= sum[TEMP_W-1:0];
         end
      end
   end

   assign rsp_temperature = temp_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

/* hdl/tvt_ctrl.sv */
module tvt_ctrl
   import tvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  tvt_sts_type sts,
   output tvt_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MUL,
      ST_INIT,
      ST_DIV,
      ST_FIX
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.load = req_valid;
         ST_SEARCH: cmd.seg_inc = !sts.oor && !sts.seg_hit;
         ST_MUL:    cmd.mul_load = 1'b1;
         ST_INIT:   cmd.div_init = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_FIX:    cmd.res_load = out_free;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIX)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (sts.oor) begin
                  state_ff <= ST_FIX;
               end else if (sts.seg_hit) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_INIT;
            ST_INIT: begin
               cnt_ff <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               // The finished result waits here until the output register is free.
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* hdl/thermistor_voltage_to_temperature_top.sv */
// Thermistor voltage to temperature converter.
// The req_ channel takes one sense voltage per transaction in 0.1 mV units.
// The rsp_ channel returns one transaction per input: the temperature in
// 0.01 degC units, interpolated in a fixed 33-point table, and an
// out-of-range flag, with the temperature forced to zero when the flag is set.
// One transaction is in work at a time; req_ready is high only while idle.
// An in-range transaction runs from acceptance through the segment search,
// one step per segment, then the multiply, the divider setup, the
// bit-serial divider and the result register, and then raises rsp_valid. An
// out-of-range voltage goes from the search straight to the result register.
// The result sits in an output register, so a new transaction is accepted while
// the previous result waits; if the receiver still stalls when the next
// result is done, the block holds that result and accepts nothing until the
// output register frees up.
// Synchronous reset returns the controller to idle and drops rsp_valid.
module thermistor_voltage_to_temperature_top
   import tvt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [VOLT_W-1:0]        req_sense_voltage,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_out_of_range
);

   tvt_cmd_type cmd;
   tvt_sts_type sts;

   tvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tvt_dp u_dp (
      .clock             (clock),
      .req_sense_voltage (req_sense_voltage),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_temperature   (rsp_temperature),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

/* hdl/tvt_chk.sv */
module tvt_chk
   import tvt_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] rsp_temperature,
   input logic                     rsp_out_of_range
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature)
         && $stable(rsp_out_of_range))
      else $error("stalled result changed");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_temperature == '0)
      else $error("out-of-range result has nonzero temperature");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |->
         rsp_temperature >= -15'sd4000 && rsp_temperature <= 15'sd12000)
      else $error("temperature outside table range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

endmodule

bind thermistor_voltage_to_temperature_top tvt_chk u_tvt_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_temperature   (rsp_temperature),
   .rsp_out_of_range  (rsp_out_of_range)
);

/* sim/tb_thermistor_voltage_to_temperature_top.sv */
module tb_thermistor_voltage_to_temperature_top;

   timeunit 1ns;
   timeprecision 1ps;

   import tvt_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 100;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [VOLT_W-1:0]        req_sense_voltage = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic                     rsp_out_of_range;

   // Stimulus waiting to be sent, with the idle gap before each item and a
   // flag that holds the item back until every expected result has arrived.
   logic [VOLT_W-1:0]        pending_voltage[$];
   int                       pending_gap[$];
   bit                       pending_drain[$];

   logic signed [TEMP_W-1:0] expected_temperature[$];
   logic                     expected_out_of_range[$];

   int                       items_total = 0;
   int                       items_sent = 0;
   int                       error_count = 0;
   int                       cycle_count = 0;
   int                       stall_left = 0;

   thermistor_voltage_to_temperature_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sense_voltage (req_sense_voltage),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_temperature   (rsp_temperature),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Piecewise linear lookup: the first segment whose lower voltage lies
   // strictly below the input, with the bottom endpoint kept in the last one.
   function automatic void interpolate_temperature(
      input  logic [VOLT_W-1:0]        voltage,
      output logic signed [TEMP_W-1:0] temperature,
      output logic                     out_of_range
   );
      longint v;
      longint x1;
      longint x2;
      longint y1;
      longint y2;
      longint t;
      int     seg;
      v = voltage;
      temperature = '0;
      out_of_range = 1'b0;
      if (v > longint'(VOLT_TAB[0]) || v < longint'(VOLT_TAB[TABLE_POINTS-1])) begin
         out_of_range = 1'b1;
      end else begin
         seg = 0;
         while (seg < TABLE_POINTS - 2 && v <= longint'(VOLT_TAB[seg+1])) seg++;
         x1 = VOLT_TAB[seg];
         x2 = VOLT_TAB[seg+1];
         y1 = TEMP_TAB[seg];
         y2 = TEMP_TAB[seg+1];
         t = y1;
         if (x2 != x1) t = y1 + ((v - x1) * (y2 - y1)) / (x2 - x1);
         temperature = t[TEMP_W-1:0];
      end
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VOLT_W-1:0] draw_voltage();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 70) return VOLT_W'($urandom_range(13000, 24400));
      if (r < 88) begin
         v = int'(VOLT_TAB[$urandom_range(0, TABLE_POINTS - 1)]) + $urandom_range(0, 4) - 2;
         return v[VOLT_W-1:0];
      end
      return VOLT_W'($urandom_range(0, 65535));
   endfunction

   task automatic queue_voltage(input logic [VOLT_W-1:0] voltage, input int gap,
                                input bit drain);
      pending_voltage.push_back(voltage);
      pending_gap.push_back(gap);
      pending_drain.push_back(drain);
      items_total++;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR: cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // Driver.
   always @(posedge clock) begin
      logic                     busy;
      logic signed [TEMP_W-1:0] temperature;
      logic                     out_of_range;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid;
         if (req_valid && req_ready) begin
            interpolate_temperature(req_sense_voltage, temperature, out_of_range);
            expected_temperature.push_back(temperature);
            expected_out_of_range.push_back(out_of_range);
            items_sent++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (pending_voltage.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_gap[0] > 0) begin
               pending_gap[0] = pending_gap[0] - 1;
               req_valid <= 1'b0;
            end else if (pending_drain[0] && expected_temperature.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_sense_voltage <= pending_voltage.pop_front();
               void'(pending_gap.pop_front());
               void'(pending_drain.pop_front());
            end
         end
      end
   end

   // Monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_temperature.size() == 0) begin
               report_mismatch("expected results waiting", 0, 1);
            end else begin
               if (rsp_temperature !== expected_temperature[0])
                  report_mismatch("temperature", int'(rsp_temperature),
                                  int'(expected_temperature[0]));
               if (rsp_out_of_range !== expected_out_of_range[0])
                  report_mismatch("out_of_range", int'(rsp_out_of_range),
                                  int'(expected_out_of_range[0]));
               void'(expected_temperature.pop_front());
               void'(expected_out_of_range.pop_front());
            end
         end
         // There are recurring stretches in which no new stalls start.
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if ((cycle_count % 3000) >= 600 && $urandom_range(0, 3) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("tb_thermistor_voltage_to_temperature_top failed");
         $finish;
      end
   end

   initial begin
      int gap;
      // Directed: both rails, the table ends and their neighbors, inner points.
      queue_voltage(16'd0, 0, 1'b0);
      queue_voltage(16'd65535, 0, 1'b0);
      queue_voltage(16'd24401, 0, 1'b0);
      queue_voltage(16'd24400, 0, 1'b0);
      queue_voltage(16'd24399, 1, 1'b0);
      queue_voltage(16'd12999, 0, 1'b0);
      queue_voltage(16'd13000, 0, 1'b0);
      queue_voltage(16'd13001, 2, 1'b0);
      queue_voltage(16'd13100, 0, 1'b0);
      queue_voltage(16'd21700, 0, 1'b0);
      queue_voltage(16'd21699, 0, 1'b0);
      queue_voltage(16'd21701, 0, 1'b0);
      queue_voltage(16'd24200, 0, 1'b0);
      queue_voltage(16'd18000, 0, 1'b0);
      queue_voltage(16'd15001, 0, 1'b0);
      queue_voltage(16'd20123, 0, 1'b0);
      queue_voltage(16'd13799, 0, 1'b0);
      queue_voltage(16'd32768, 0, 1'b0);
      queue_voltage(16'd21845, 0, 1'b0);
      queue_voltage(16'd43690, 0, 1'b0);
      queue_voltage(16'd13201, 0, 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gap = ((i / 100) % 3 == 2) ? 0 : draw_gap();
         queue_voltage(draw_voltage(), gap, (i == 200) || (i == 450));
      end

      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (items_sent < items_total || expected_temperature.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_thermistor_voltage_to_temperature_top passed");
      else
         $display("tb_thermistor_voltage_to_temperature_top failed");
      $finish;
   end

endmodule
